@@ rtl/aes_pkg.sv @@
`timescale 1ns / 1ps
package aes_pkg;

  localparam int unsigned NumKeyEntries = 15;
  localparam int unsigned KeyIdxW = 4;
  localparam int unsigned WordCntW = 6;

  typedef enum logic [2:0] {
    CfgKey0 = 3'd0,
    CfgKey1 = 3'd1,
    CfgKey2 = 3'd2,
    CfgKey3 = 3'd3,
    CfgMode = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StExpInit,
    StExpand,
    StFirst,
    StRound,
    StDone
  } aes_state_e;

  typedef struct packed {
    logic               load_block;
    logic               dec;
    logic               exp_init;
    logic               exp_step;
    logic               first_key;
    logic               round_step;
    logic               last_round;
    logic [KeyIdxW-1:0] key_idx;
  } aes_cmd_t;

  typedef struct packed {
    logic [3:0] nr;
    logic       exp_done;
  } aes_sts_t;

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xt(x);
    end
    gmul = p;
  endfunction

  function automatic logic [7:0] ginv(input logic [7:0] a);
    logic [7:0] r;
    logic [7:0] b;
    r = 8'h01;
    b = a;
    for (int i = 0; i < 8; i++) begin
      if (i != 0) r = gmul(r, b);
      b = gmul(b, b);
    end
    ginv = r;
  endfunction

  function automatic logic [7:0] rl(input logic [7:0] x, input int n);
    rl = (x << n) | (x >> (8 - n));
  endfunction

  function automatic logic [7:0] sbox_calc(input logic [7:0] x);
    logic [7:0] v;
    v = ginv(x);
    sbox_calc = v ^ rl(v, 1) ^ rl(v, 2) ^ rl(v, 3) ^ rl(v, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] isbox_calc(input logic [7:0] x);
    isbox_calc = ginv(rl(x, 1) ^ rl(x, 3) ^ rl(x, 6) ^ 8'h05);
  endfunction

  typedef logic [7:0] lut_t [256];

  function automatic lut_t mk_sbox(input logic inv);
    lut_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = inv ? isbox_calc(8'(i)) : sbox_calc(8'(i));
    end
    return t;
  endfunction

  localparam lut_t SBOX = mk_sbox(1'b0);
  localparam lut_t ISBOX = mk_sbox(1'b1);

endpackage

@@ rtl/aes_ctrl.sv @@
`timescale 1ns / 1ps
module aes_ctrl import aes_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic     func_i,
  input  logic     key_stale_i,
  input  aes_sts_t sts_i,
  output logic     busy_o,
  output logic     sched_ok_o,
  output logic     done_o,
  output aes_cmd_t cmd_o
);

  aes_state_e state_q, state_d;
  logic [3:0] rnd_q, rnd_d;
  logic       dec_q, dec_d;
  logic       ok_q, ok_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      rnd_q   <= '0;
      dec_q   <= 1'b0;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      dec_q   <= dec_d;
      ok_q    <= ok_d;
    end
  end

  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    dec_d   = dec_q;
    ok_d    = ok_q && !key_stale_i;
    cmd_o   = '0;
    cmd_o.dec = dec_q;
    busy_o  = (state_q != StIdle);
    done_o  = 1'b0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load_block = 1'b1;
          cmd_o.key_idx = func_i ? sts_i.nr : 4'd0;
          dec_d = func_i;
          state_d = ok_q ? StFirst : StExpInit;
        end
      end
      StExpInit: begin
        cmd_o.exp_init = 1'b1;
        state_d = StExpand;
      end
      StExpand: begin
        cmd_o.exp_step = 1'b1;
        if (sts_i.exp_done) begin
          cmd_o.key_idx = dec_q ? sts_i.nr : 4'd0;
          ok_d = 1'b1;
          state_d = StFirst;
        end
      end
      StFirst: begin
        cmd_o.first_key = 1'b1;
        cmd_o.key_idx = dec_q ? sts_i.nr - 4'd1 : 4'd1;
        rnd_d = 4'd1;
        state_d = StRound;
      end
      StRound: begin
        cmd_o.round_step = 1'b1;
        cmd_o.last_round = (rnd_q == sts_i.nr);
        if (rnd_q != sts_i.nr) begin
          cmd_o.key_idx = dec_q ? sts_i.nr - rnd_q - 4'd1 : rnd_q + 4'd1;
        end
        rnd_d = rnd_q + 4'd1;
        if (rnd_q == sts_i.nr) state_d = StDone;
      end
      StDone: begin
        done_o = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign sched_ok_o = ok_q;

endmodule

@@ rtl/aes_dp.sv @@
`timescale 1ns / 1ps
module aes_dp import aes_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  aes_cmd_t     cmd_i,
  input  logic [63:0]  block_high_i,
  input  logic [63:0]  block_low_i,
  input  logic [255:0] key_i,
  input  logic [1:0]   mode_i,
  output aes_sts_t     sts_o,
  output logic [127:0] state_o
);

  logic [127:0] rk_mem [NumKeyEntries];
  logic [127:0] rk_q;
  logic [127:0] st_q, st_d;
  logic [255:0] win_q, win_d;
  logic [WordCntW-1:0] wi_q, wi_d;
  logic [7:0]   rc_q, rc_d;
  logic [3:0]   nr;
  logic [3:0]   nk;
  logic [5:0]   total;
  logic         exp_done;
  logic [31:0]  t_w, new_w, prev_w;
  logic [2:0]   ph_q, ph_d;
  logic [31:0]  acc_q [4];

  always_comb begin
    case (mode_i)
      2'd0: nr = 4'd10;
      2'd1: nr = 4'd12;
      default: nr = 4'd14;
    endcase
  end
  assign nk = nr - 4'd6;
  assign total = 6'(({2'b00, nr} + 6'd1) << 2);
  assign exp_done = (wi_q >= total);
  assign sts_o.nr = nr;
  assign sts_o.exp_done = exp_done;

  // window holds the last nk words, newest at the bottom
  always_comb begin
    prev_w = win_q[31:0];
    t_w = prev_w;
    if (ph_q == 3'd0) begin
      t_w = {SBOX[prev_w[23:16]] ^ rc_q, SBOX[prev_w[15:8]],
             SBOX[prev_w[7:0]], SBOX[prev_w[31:24]]};
    end else if (nk > 4'd6 && ph_q == 3'd4) begin
      t_w = {SBOX[prev_w[31:24]], SBOX[prev_w[23:16]],
             SBOX[prev_w[15:8]], SBOX[prev_w[7:0]]};
    end
    new_w = win_q[32*nk-1 -: 32] ^ t_w;
  end

  always_comb begin
    win_d = win_q;
    wi_d = wi_q;
    rc_d = rc_q;
    ph_d = ph_q;
    if (cmd_i.exp_init) begin
      win_d = '0;
      for (int i = 0; i < 8; i++) begin
        if (4'(i) < nk) win_d[32*(nk-4'(i))-1 -: 32] = key_i[255-32*i -: 32];
      end
      wi_d = 6'(nk);
      rc_d = 8'h01;
      ph_d = 3'd0;
    end else if (cmd_i.exp_step && !exp_done) begin
      win_d = {win_q[223:0], new_w};
      wi_d = wi_q + 6'd1;
      if (ph_q == 3'd0) rc_d = xt(rc_q);
      ph_d = (ph_q + 3'd1 == 3'(nk)) ? 3'd0 : ph_q + 3'd1;
      if (nk == 4'd6 && ph_q == 3'd5) ph_d = 3'd0;
      if (nk == 4'd4 && ph_q == 3'd3) ph_d = 3'd0;
    end
  end

  // gather words into 128-bit round keys; words before nk come from the key
  logic [127:0] cur_rk;
  logic [5:0]   wi_n;
  assign wi_n = wi_q + 6'd1;
  assign cur_rk = {acc_q[1], acc_q[2], acc_q[3], new_w};

  always_ff @(posedge clk_i) begin
    if (cmd_i.exp_init) begin
      for (int i = 0; i < 4; i++) acc_q[i] <= key_i[255-32*(i+int'(nk)-4) -: 32];
    end else if (cmd_i.exp_step && !exp_done) begin
      acc_q[0] <= acc_q[1];
      acc_q[1] <= acc_q[2];
      acc_q[2] <= acc_q[3];
      acc_q[3] <= new_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wi_q <= '0;
      ph_q <= '0;
      rc_q <= 8'h01;
    end else begin
      wi_q <= wi_d;
      ph_q <= ph_d;
      rc_q <= rc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    if (cmd_i.exp_init) begin
      rk_mem[0] <= key_i[255:128];
      if (nk == 4'd8) rk_mem[1] <= key_i[127:0];
    end else if (cmd_i.exp_step && !exp_done && wi_n[1:0] == 2'd0) begin
      rk_mem[wi_q[5:2]] <= cur_rk;
    end
    rk_q <= rk_mem[cmd_i.key_idx];
  end

  // round unit
  function automatic logic [127:0] sub_b(input logic [127:0] s, input logic inv);
    for (int i = 0; i < 16; i++) begin
      s[127-8*i -: 8] = inv ? ISBOX[s[127-8*i -: 8]] : SBOX[s[127-8*i -: 8]];
    end
    return s;
  endfunction

  function automatic logic [127:0] shr(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv) t[127-8*(((c+r)%4)*4+r) -: 8] = s[127-8*(c*4+r) -: 8];
        else t[127-8*(c*4+r) -: 8] = s[127-8*(((c+r)%4)*4+r) -: 8];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mixc(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    logic [7:0] m [4];
    logic [7:0] acc;
    if (inv) m = '{8'd14, 8'd11, 8'd13, 8'd9};
    else m = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int k = 0; k < 4; k++) begin
          acc = acc ^ gmul(s[127-8*(4*c+k) -: 8], m[(k+4-r)%4]);
        end
        t[127-8*(4*c+r) -: 8] = acc;
      end
    end
    return t;
  endfunction

  // rk_q is a registered read of rk_mem; the index is presented in the state before the key is used
  logic [127:0] fwd_v, inv_v;
  always_comb begin
    fwd_v = shr(sub_b(st_q, 1'b0), 1'b0);
    if (!cmd_i.last_round) fwd_v = mixc(fwd_v, 1'b0);
    inv_v = sub_b(shr(st_q, 1'b1), 1'b1) ^ rk_q;
    if (!cmd_i.last_round) inv_v = mixc(inv_v, 1'b1);
    st_d = st_q;
    if (cmd_i.load_block) st_d = {block_high_i, block_low_i};
    else if (cmd_i.first_key) st_d = st_q ^ rk_q;
    else if (cmd_i.round_step) st_d = cmd_i.dec ? inv_v : fwd_v ^ rk_q;
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign state_o = st_q;

endmodule

@@ rtl/aes_block_cipher.sv @@
`timescale 1ns / 1ps
// channel  | handshake            | payload
// input    | start / busy         | func_i, block_high_i, block_low_i
// config   | cfg_valid_i/ready_o  | cfg_index_i, cfg_data_i
// result   | result_valid_o       | result_high_o, result_low_o
// A block runs first key, rounds and done on the shared round unit;
// the result shows in done, registered from the last round.
// After a key or mode write the first block first expands the schedule
// in the expand init and expand states, one key word per cycle.
// Reset clears the controller; round keys are rebuilt before first use.
// The receiver cannot stall: the result is shown for one cycle.
module aes_block_cipher import aes_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        func_i,
  input  logic [63:0] block_high_i,
  input  logic [63:0] block_low_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [63:0] result_high_o,
  output logic [63:0] result_low_o
);

  logic [63:0] k0_q, k1_q, k2_q, k3_q;
  logic [1:0]  mode_q;
  logic        cfg_we, stale;
  aes_cmd_t    cmd;
  aes_sts_t    sts;
  logic        done, sched_ok;
  logic [127:0] st;

  assign cfg_ready_o = 1'b1;
  assign cfg_we = cfg_valid_i && cfg_ready_o;
  assign stale = cfg_we && (cfg_index_i <= CfgMode);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k0_q <= '0;
      k1_q <= '0;
      k2_q <= '0;
      k3_q <= '0;
      mode_q <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgKey0: k0_q <= cfg_data_i;
        CfgKey1: k1_q <= cfg_data_i;
        CfgKey2: k2_q <= cfg_data_i;
        CfgKey3: k3_q <= cfg_data_i;
        CfgMode: mode_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  aes_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .start_i(start), .func_i, .key_stale_i(stale), .sts_i(sts),
    .busy_o(busy), .sched_ok_o(sched_ok), .done_o(done), .cmd_o(cmd)
  );

  aes_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .block_high_i, .block_low_i,
    .key_i({k0_q, k1_q, k2_q, k3_q}), .mode_i(mode_q),
    .sts_o(sts), .state_o(st)
  );

  assign result_valid_o = done;
  assign result_high_o = st[127:64];
  assign result_low_o = st[63:0];

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy) else $error("result outside busy");
  a_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result held");
  a_start_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("start not taken");
  a_sched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.round_step |-> sched_ok) else $error("round before schedule");

endmodule

@@ tb/tb_aes_block_cipher.sv @@
`timescale 1ns / 1ps
module tb_aes_block_cipher import aes_pkg::*; ();

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        func_i;
  logic [63:0] block_high_i;
  logic [63:0] block_low_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [63:0] cfg_data_i;
  logic        result_valid_o;
  logic [63:0] result_high_o;
  logic [63:0] result_low_o;

  aes_block_cipher DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .func_i(func_i),
    .block_high_i(block_high_i),
    .block_low_i(block_low_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .result_valid_o(result_valid_o),
    .result_high_o(result_high_o),
    .result_low_o(result_low_o)
  );

  logic [63:0]  key_reg [4];
  logic [1:0]   key_mode;
  logic [127:0] sched_keys [15];
  bit           keys_fresh;
  logic [127:0] blocks_due [$];
  int           errors;
  int           gap_pct;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("** aes_block_cipher: FAILED **");
    $finish;
  end

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  function automatic logic [7:0] gf_inverse(logic [7:0] a);
    logic [7:0] r;
    r = 8'h01;
    for (int e = 0; e < 254; e++) r = gf_mul(r, a);
    return r;
  endfunction

  function automatic logic [7:0] rot8(logic [7:0] x, int n);
    return (x << n) | (x >> (8 - n));
  endfunction

  function automatic logic [7:0] sub_byte(logic [7:0] x, bit inv);
    logic [7:0] v;
    if (inv) return gf_inverse(rot8(x, 1) ^ rot8(x, 3) ^ rot8(x, 6) ^ 8'h05);
    v = gf_inverse(x);
    return v ^ rot8(v, 1) ^ rot8(v, 2) ^ rot8(v, 3) ^ rot8(v, 4) ^ 8'h63;
  endfunction

  logic [7:0] sb_fwd [256];
  logic [7:0] sb_inv [256];

  function automatic int round_count();
    return (key_mode == 2'd0) ? 10 : (key_mode == 2'd1) ? 12 : 14;
  endfunction

  function automatic void expand_schedule();
    logic [7:0] w [60][4];
    logic [7:0] t [4];
    logic [7:0] kb [32];
    logic [7:0] rc;
    logic [7:0] f;
    int nr;
    int nk;
    nr = round_count();
    nk = nr - 6;
    rc = 8'h01;
    for (int i = 0; i < 32; i++) kb[i] = key_reg[i / 8][63 - 8 * (i % 8) -: 8];
    for (int i = 0; i < nk; i++)
      for (int j = 0; j < 4; j++) w[i][j] = kb[4 * i + j];
    for (int i = nk; i < 4 * (nr + 1); i++) begin
      t = w[i - 1];
      if (i % nk == 0) begin
        f = t[0];
        t[0] = sb_fwd[t[1]] ^ rc;
        t[1] = sb_fwd[t[2]];
        t[2] = sb_fwd[t[3]];
        t[3] = sb_fwd[f];
        rc = gf_mul(rc, 8'h02);
      end else if (nk > 6 && i % nk == 4) begin
        for (int j = 0; j < 4; j++) t[j] = sb_fwd[t[j]];
      end
      for (int j = 0; j < 4; j++) w[i][j] = w[i - nk][j] ^ t[j];
    end
    for (int r = 0; r <= nr; r++)
      for (int j = 0; j < 16; j++) sched_keys[r][127 - 8 * j -: 8] = w[4 * r + j / 4][j % 4];
    keys_fresh = 1'b1;
  endfunction

  function automatic logic [127:0] cipher_block(bit dec, logic [127:0] blk);
    logic [7:0] s [16];
    logic [7:0] u [16];
    logic [7:0] col [4];
    logic [7:0] m [4];
    logic [127:0] o;
    int nr;
    int r;
    if (!keys_fresh) expand_schedule();
    nr = round_count();
    if (dec) m = '{8'd14, 8'd11, 8'd13, 8'd9};
    else m = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int i = 0; i < 16; i++) s[i] = blk[127 - 8 * i -: 8];
    r = dec ? nr : 0;
    for (int i = 0; i < 16; i++) s[i] ^= sched_keys[r][127 - 8 * i -: 8];
    for (int k = 1; k <= nr; k++) begin
      r = dec ? nr - k : k;
      for (int c = 0; c < 4; c++)
        for (int q = 0; q < 4; q++)
          if (dec) u[((c + q) % 4) * 4 + q] = sb_inv[s[c * 4 + q]];
          else u[c * 4 + q] = sb_fwd[s[((c + q) % 4) * 4 + q]];
      for (int i = 0; i < 16; i++) u[i] ^= dec ? sched_keys[r][127 - 8 * i -: 8] : 8'h00;
      if (k != nr) begin
        for (int c = 0; c < 4; c++) begin
          for (int q = 0; q < 4; q++) col[q] = u[4 * c + q];
          for (int q = 0; q < 4; q++) begin
            u[4 * c + q] = 8'h00;
            for (int n = 0; n < 4; n++) u[4 * c + q] ^= gf_mul(col[n], m[(n + 4 - q) % 4]);
          end
        end
      end
      for (int i = 0; i < 16; i++)
        s[i] = u[i] ^ (dec ? 8'h00 : sched_keys[r][127 - 8 * i -: 8]);
    end
    for (int i = 0; i < 16; i++) o[127 - 8 * i -: 8] = s[i];
    return o;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgKey0: key_reg[0] = val;
      CfgKey1: key_reg[1] = val;
      CfgKey2: key_reg[2] = val;
      CfgKey3: key_reg[3] = val;
      default: key_mode = val[1:0];
    endcase
    keys_fresh = 1'b0;
  endtask

  task automatic send_block(bit dec, logic [127:0] blk);
    do @(negedge clk_i); while ($urandom_range(99) < gap_pct);
    start        <= 1'b1;
    func_i       <= dec;
    block_high_i <= blk[127:64];
    block_low_i  <= blk[63:0];
    do @(posedge clk_i); while (busy);
    blocks_due = {blocks_due, cipher_block(dec, blk)};
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (blocks_due.size() != 0 && guard < 100000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (80) @(negedge clk_i);
  endtask

  task automatic load_key(logic [1:0] mode, logic [63:0] k0, logic [63:0] k1,
                          logic [63:0] k2, logic [63:0] k3);
    drain();
    write_reg(CfgKey0, k0);
    write_reg(CfgKey1, k1);
    write_reg(CfgKey2, k2);
    write_reg(CfgKey3, k3);
    write_reg(CfgMode, {62'd0, mode});
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [127:0] rand_block();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  task automatic test_standard_vectors();
    load_key(2'd0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '0, '0);
    send_block(1'b0, 128'h00112233445566778899aabbccddeeff);
    send_block(1'b1, 128'h69c4e0d86a7b0430d8cdb78070b4c55a);
    load_key(2'd1, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617, '0);
    send_block(1'b0, 128'h00112233445566778899aabbccddeeff);
    send_block(1'b1, 128'hdda97ca4864cdfe06eaf70a0ec0d7191);
    load_key(2'd2, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
             64'h18191a1b1c1d1e1f);
    send_block(1'b0, 128'h00112233445566778899aabbccddeeff);
    send_block(1'b1, 128'h8ea2b7ca516745bfeafc49904b496089);
  endtask

  task automatic test_extremes();
    load_key(2'd3, '1, '1, '1, '1);
    send_block(1'b0, '0);
    send_block(1'b1, '1);
    load_key(2'd0, '0, '0, '1, '1);
    send_block(1'b0, '1);
    send_block(1'b1, '0);
    load_key(2'd1, '1, '1, '1, 64'h0123456789abcdef);
    send_block(1'b0, {64'h8000000000000000, 64'd1});
    send_block(1'b1, {64'd1, 64'h8000000000000000});
  endtask

  task automatic test_random_blocks(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0)
        load_key(2'($urandom_range(3)), {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom});
      send_block(1'($urandom_range(1)), rand_block());
    end
  endtask

  always @(posedge clk_i) begin
    logic [127:0] want;
    if (rst_ni && result_valid_o) begin
      if (blocks_due.size() == 0) begin
        $display("%0t: unexpected result %h %h", $time, result_high_o, result_low_o);
        errors++;
      end else begin
        want = blocks_due.pop_front();
        if (result_high_o !== want[127:64]) begin
          $display("%0t: result_high expected %h actual %h", $time, want[127:64],
                   result_high_o);
          errors++;
        end
        if (result_low_o !== want[63:0]) begin
          $display("%0t: result_low expected %h actual %h", $time, want[63:0],
                   result_low_o);
          errors++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < 256; i++) begin
      sb_fwd[i] = sub_byte(8'(i), 1'b0);
      sb_inv[i] = sub_byte(8'(i), 1'b1);
    end
    errors       = 0;
    gap_pct      = 0;
    key_reg      = '{default: '0};
    key_mode     = 2'd0;
    keys_fresh   = 1'b0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    func_i       = 1'b0;
    block_high_i = '0;
    block_low_i  = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CfgKey0;
    cfg_data_i   = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    send_block(1'b0, rand_block());
    test_standard_vectors();
    test_extremes();
    gap_pct = 8;
    test_random_blocks(510);
    gap_pct = 50;
    test_random_blocks(510);
    gap_pct = 0;
    test_random_blocks(510);
    drain();
    if (errors == 0 && blocks_due.size() == 0) begin
      $display("** aes_block_cipher: PASSED **");
    end else begin
      $display("** aes_block_cipher: FAILED **");
    end
    $finish;
  end

endmodule
